// ===== rtl/graph_component_labeller_top_defines.svh =====
// Assertion macros for the graph component labeller.
// Sampled on clk, disabled while rst_n is low; ASSERT_OFF removes them.
`ifndef GRAPH_COMPONENT_LABELLER_TOP_DEFINES_SVH
`define GRAPH_COMPONENT_LABELLER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define GLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define GLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GLC_ASSERT(lbl, prop, msg)
`define GLC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/glc_pkg.sv =====
// Shared constants, state type and cell control bundle of the labeller.
// No dependencies.
package glc_pkg;

    localparam int MAX_NODES = 64;
    localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NODE_W    = 6;
    localparam int CNT_W     = 7;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        GLC_IDLE,
        GLC_SCAN,
        GLC_GROW,
        GLC_EMIT
    } glc_state_t;

    typedef struct packed {
        logic              edge_we;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic              clear_rows;
        logic              clear_visited;
        logic              seed;
        logic [CNT_W-1:0]  seed_idx;
        logic              grow;
        logic              shift;
        logic [NODE_W-1:0] comps;
        logic [CNT_W-1:0]  count;
    } glc_cell_ctrl_t;

endpackage

// ===== rtl/glc_in_if.sv =====
// Input channel of the labeller: bond and end items.
// Depends on glc_pkg.
interface glc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [glc_pkg::NODE_W-1:0] node_a;
    logic [glc_pkg::NODE_W-1:0] node_b;
    logic [glc_pkg::CNT_W-1:0]  node_count;

    modport source (output valid, kind, node_a, node_b, node_count, input ready);
    modport sink   (input valid, kind, node_a, node_b, node_count, output ready);
endinterface

// ===== rtl/glc_out_if.sv =====
// Output channel of the labeller: one label item per node.
// Depends on glc_pkg.
interface glc_out_if;
    logic                       valid;
    logic                       ready;
    logic [glc_pkg::NODE_W-1:0] node_index;
    logic [glc_pkg::NODE_W-1:0] component_id;
    logic [glc_pkg::CNT_W-1:0]  component_count;
    logic                       last;

    modport source (output valid, node_index, component_id, component_count, last,
                    input ready);
    modport sink   (input valid, node_index, component_id, component_count, last,
                    output ready);
endinterface

// ===== rtl/graph_component_labeller_top.sv =====
// Top level of the graph component labeller: sequencer plus a row of node cells.
// Depends on glc_pkg, glc_in_if, glc_out_if, glc_cell and glc_ctrl.
//
//  channel  dir  fields                                            handshake
//  bonds    in   kind, node_a, node_b, node_count                  valid/ready
//  labels   out  node_index, component_id, component_count, last   valid/ready
//
// An end item with count N scans nodes 0 to N - 1; each unvisited node seeds a
// component that the cell row grows one frontier level at a time until the
// frontier is empty, and that loop sets the labelling time. Then N label items
// leave, one item per cycle while labels is not stalled. Bonds are refused from
// the end item until the final label item is loaded into the output register.
// Reset clears adjacency rows and control at once; no clearing pass is needed.
// A stall on labels holds the output register and the label shift chain.
module graph_component_labeller_top (
    input  logic      clk,
    input  logic      rst_n,
    glc_in_if.sink    bonds,
    glc_out_if.source labels
);
    import glc_pkg::*;

    glc_cell_ctrl_t       cell_ctrl;
    logic [MAX_NODES-1:0] frontier_vec;
    logic [MAX_NODES-1:0] visited_vec;
    logic [NODE_W-1:0]    label_w [MAX_NODES];

    glc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .bonds        (bonds),
        .labels       (labels),
        .frontier_vec (frontier_vec),
        .visited_vec  (visited_vec),
        .head_label   (label_w[0]),
        .cell_ctrl    (cell_ctrl)
    );

    genvar gi;
    generate
        for (gi = 0; gi < MAX_NODES; gi++)
        begin : g_cell
            logic [NODE_W-1:0] next_label;
            if (gi == MAX_NODES - 1)
            begin : g_tail
                assign next_label = '0;
            end
            else
            begin : g_link
                assign next_label = label_w[gi+1];
            end

            glc_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .cell_idx     (CNT_W'(gi)),
                .ctrl         (cell_ctrl),
                .frontier_vec (frontier_vec),
                .label_in     (next_label),
                .frontier     (frontier_vec[gi]),
                .visited      (visited_vec[gi]),
                .label_out    (label_w[gi])
            );
        end
    endgenerate

endmodule

// ===== rtl/glc_cell.sv =====
// One node cell: adjacency row, visited and frontier bits, label.
// Labels shift toward cell 0 during output. Depends on glc_pkg.
module glc_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [glc_pkg::CNT_W-1:0]         cell_idx,
    input  glc_pkg::glc_cell_ctrl_t           ctrl,
    input  logic [glc_pkg::MAX_NODES-1:0]     frontier_vec,
    input  logic [glc_pkg::NODE_W-1:0]        label_in,
    output logic                              frontier,
    output logic                              visited,
    output logic [glc_pkg::NODE_W-1:0]        label_out
);
    import glc_pkg::*;

    logic [MAX_NODES-1:0] row_reg;
    logic [MAX_NODES-1:0] row_next;
    logic                 visited_reg;
    logic                 visited_next;
    logic                 frontier_reg;
    logic                 frontier_next;
    logic [NODE_W-1:0]    label_reg;
    logic [NODE_W-1:0]    label_next;
    logic                 in_graph;
    logic                 hit;
    logic [MAX_NODES-1:0] one_hot;

    assign one_hot  = {{(MAX_NODES-1){1'b0}}, 1'b1};
    assign in_graph = cell_idx < ctrl.count;
    assign hit      = in_graph && !visited_reg && (|(row_reg & frontier_vec));

    always_comb
    begin
        row_next = row_reg;
        if (ctrl.clear_rows)
        begin
            row_next = '0;
        end
        else if (ctrl.edge_we)
        begin
            if ({1'b0, ctrl.node_a} == cell_idx)
            begin
                row_next = row_next | (one_hot << ctrl.node_b);
            end
            if ({1'b0, ctrl.node_b} == cell_idx)
            begin
                row_next = row_next | (one_hot << ctrl.node_a);
            end
        end
    end

    always_comb
    begin
        visited_next  = visited_reg;
        frontier_next = frontier_reg;
        label_next    = label_reg;
        if (ctrl.clear_visited)
        begin
            visited_next  = 1'b0;
            frontier_next = 1'b0;
        end
        else if (ctrl.seed && (ctrl.seed_idx == cell_idx))
        begin
            visited_next  = 1'b1;
            frontier_next = 1'b1;
            label_next    = ctrl.comps;
        end
        else if (ctrl.grow)
        begin
            frontier_next = hit;
            if (hit)
            begin
                visited_next = 1'b1;
                label_next   = ctrl.comps;
            end
        end
        else if (ctrl.shift)
        begin
            label_next = label_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            visited_reg  <= 1'b0;
            frontier_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            visited_reg  <= visited_next;
            frontier_reg <= frontier_next;
        end
    end

    always_ff @(posedge clk)
    begin
        label_reg <= label_next;
    end

    assign frontier  = frontier_reg;
    assign visited   = visited_reg;
    assign label_out = label_reg;

endmodule

// ===== rtl/glc_ctrl.sv =====
// Sequencer: edge loading, seed scan, frontier growth and label output.
// Depends on glc_pkg, glc_in_if, glc_out_if and the assertion macros.
`include "graph_component_labeller_top_defines.svh"

module glc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    glc_in_if.sink                        bonds,
    glc_out_if.source                     labels,
    input  logic [glc_pkg::MAX_NODES-1:0] frontier_vec,
    input  logic [glc_pkg::MAX_NODES-1:0] visited_vec,
    input  logic [glc_pkg::NODE_W-1:0]    head_label,
    output glc_pkg::glc_cell_ctrl_t       cell_ctrl
);
    import glc_pkg::*;

    glc_state_t        state_reg;
    glc_state_t        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  start_reg;
    logic [CNT_W-1:0]  start_next;
    logic [CNT_W-1:0]  comps_reg;
    logic [CNT_W-1:0]  comps_next;
    logic [CNT_W-1:0]  emit_idx_reg;
    logic [CNT_W-1:0]  emit_idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [NODE_W-1:0] out_index_reg;
    logic [NODE_W-1:0] out_id_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_last_reg;

    logic              accept;
    logic              load_out;
    logic              emit_last;
    logic              start_done;
    logic              start_seen;
    logic [CNT_W-1:0]  count_sat;
    logic [CNT_W-1:0]  count_last;

    assign accept     = bonds.valid && bonds.ready;
    assign count_sat  = (bonds.node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                               : bonds.node_count;
    assign count_last = count_reg - CNT_W'(1);
    assign emit_last  = emit_idx_reg == count_last;
    assign start_done = start_reg == count_reg;
    assign start_seen = visited_vec[start_reg[IDX_W-1:0]];

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        start_next    = start_reg;
        comps_next    = comps_reg;
        emit_idx_next = emit_idx_reg;
        case (state_reg)
            GLC_IDLE:
            begin
                if (accept && (bonds.kind == KIND_END))
                begin
                    count_next = count_sat;
                    start_next = '0;
                    comps_next = '0;
                    if (count_sat != '0)
                    begin
                        state_next = GLC_SCAN;
                    end
                end
            end
            GLC_SCAN:
            begin
                if (start_done)
                begin
                    emit_idx_next = '0;
                    state_next    = GLC_EMIT;
                end
                else
                begin
                    start_next = start_reg + CNT_W'(1);
                    if (!start_seen)
                    begin
                        state_next = GLC_GROW;
                    end
                end
            end
            GLC_GROW:
            begin
                if (frontier_vec == '0)
                begin
                    comps_next = comps_reg + CNT_W'(1);
                    state_next = GLC_SCAN;
                end
            end
            GLC_EMIT:
            begin
                if (load_out)
                begin
                    emit_idx_next = emit_idx_reg + CNT_W'(1);
                    if (emit_last)
                    begin
                        state_next = GLC_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = GLC_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bonds.ready             = 1'b0;
        load_out                = 1'b0;
        cell_ctrl               = '0;
        cell_ctrl.node_a        = bonds.node_a;
        cell_ctrl.node_b        = bonds.node_b;
        cell_ctrl.seed_idx      = start_reg;
        cell_ctrl.comps         = comps_reg[NODE_W-1:0];
        cell_ctrl.count         = count_reg;
        case (state_reg)
            GLC_IDLE:
            begin
                bonds.ready = 1'b1;
                if (bonds.valid && (bonds.kind == KIND_EDGE))
                begin
                    cell_ctrl.edge_we = ({1'b0, bonds.node_a} < CNT_W'(MAX_NODES))
                                     && ({1'b0, bonds.node_b} < CNT_W'(MAX_NODES));
                end
                if (bonds.valid && (bonds.kind == KIND_END))
                begin
                    cell_ctrl.clear_visited = 1'b1;
                    cell_ctrl.clear_rows    = count_sat == '0;
                end
            end
            GLC_SCAN:
            begin
                cell_ctrl.clear_rows = start_done;
                cell_ctrl.seed       = !start_done && !start_seen;
            end
            GLC_GROW:
            begin
                cell_ctrl.grow = frontier_vec != '0;
            end
            GLC_EMIT:
            begin
                load_out        = !out_valid_reg || labels.ready;
                cell_ctrl.shift = load_out;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (labels.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= GLC_IDLE;
            count_reg     <= '0;
            start_reg     <= '0;
            comps_reg     <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            comps_reg     <= comps_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_index_reg <= emit_idx_reg[NODE_W-1:0];
            out_id_reg    <= head_label;
            out_count_reg <= comps_reg;
            out_last_reg  <= emit_last;
        end
    end

    assign labels.valid           = out_valid_reg;
    assign labels.node_index      = out_index_reg;
    assign labels.component_id    = out_id_reg;
    assign labels.component_count = out_count_reg;
    assign labels.last            = out_last_reg;

    `GLC_ASSERT(a_emit_range, (state_reg == GLC_EMIT) |-> (emit_idx_reg < count_reg), "emit index past node count")
    `GLC_ASSERT(a_comps_bound, (state_reg == GLC_SCAN) |-> (comps_reg <= start_reg), "more components than scanned nodes")
    `GLC_ASSERT_NEXT(a_seed_front, cell_ctrl.seed, frontier_vec != '0, "seed left an empty frontier")
    `GLC_ASSERT_NEXT(a_last_idle, load_out && emit_last, state_reg == GLC_IDLE, "no return to idle after final item")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for graph_component_labeller_top: bond and end items in,
// per-node component labels out, compared against an in-bench labeller.
// Depends on glc_pkg, glc_in_if, glc_out_if and the labeller RTL.
module testbench;
    import glc_pkg::*;

    localparam int DIRECTED_ROWS = 21;
    localparam int RANDOM_ITEMS  = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int BURST_FIRST   = 110;
    localparam int BURST_LAST    = 170;

    typedef enum logic [1:0] {
        RULE_PREDICT,
        RULE_ISOLATED,
        RULE_SINGLE
    } label_rule_t;

    typedef struct {
        logic              kind;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [CNT_W-1:0]  node_count;
        label_rule_t       rule;
    } bond_item_t;

    typedef struct {
        logic [NODE_W-1:0] node_index;
        logic [NODE_W-1:0] component_id;
        logic [CNT_W-1:0]  component_count;
        logic              last;
    } label_t;

    logic        clk = 1'b0;
    logic        rst_n;
    label_rule_t label_rule;
    logic        burst;
    logic        hold_request;
    int          offered;
    int          errors;

    logic [MAX_NODES-1:0] bond_rows [MAX_NODES];
    label_t               expected_labels [$];

    bond_item_t directed_bonds [DIRECTED_ROWS] = '{
        '{KIND_END,  6'd0,  6'd0,  7'd1,   RULE_ISOLATED},
        '{KIND_END,  6'd0,  6'd0,  7'd0,   RULE_ISOLATED},
        '{KIND_END,  6'd63, 6'd0,  7'd64,  RULE_ISOLATED},
        '{KIND_END,  6'd0,  6'd63, 7'd127, RULE_ISOLATED},
        '{KIND_EDGE, 6'd0,  6'd63, 7'd127, RULE_PREDICT},
        '{KIND_EDGE, 6'd63, 6'd0,  7'd0,   RULE_PREDICT},
        '{KIND_EDGE, 6'd5,  6'd5,  7'd0,   RULE_PREDICT},
        '{KIND_EDGE, 6'd1,  6'd2,  7'd0,   RULE_PREDICT},
        '{KIND_EDGE, 6'd2,  6'd40, 7'd0,   RULE_PREDICT},
        '{KIND_EDGE, 6'd40, 6'd63, 7'd0,   RULE_PREDICT},
        '{KIND_END,  6'd63, 6'd63, 7'd64,  RULE_PREDICT},
        '{KIND_EDGE, 6'd3,  6'd10, 7'd0,   RULE_PREDICT},
        '{KIND_EDGE, 6'd10, 6'd4,  7'd0,   RULE_PREDICT},
        '{KIND_END,  6'd0,  6'd0,  7'd8,   RULE_PREDICT},
        '{KIND_EDGE, 6'd0,  6'd1,  7'd0,   RULE_PREDICT},
        '{KIND_EDGE, 6'd1,  6'd2,  7'd0,   RULE_PREDICT},
        '{KIND_EDGE, 6'd3,  6'd2,  7'd0,   RULE_PREDICT},
        '{KIND_END,  6'd0,  6'd0,  7'd4,   RULE_SINGLE},
        '{KIND_EDGE, 6'd7,  6'd8,  7'd0,   RULE_PREDICT},
        '{KIND_END,  6'd0,  6'd0,  7'd0,   RULE_PREDICT},
        '{KIND_END,  6'd0,  6'd0,  7'd16,  RULE_ISOLATED}
    };

    glc_in_if  bonds ();
    glc_out_if labels ();

    graph_component_labeller_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bonds  (bonds),
        .labels (labels)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic record_bond(input bond_item_t it);
        logic [MAX_NODES-1:0] in_range;
        logic [MAX_NODES-1:0] seen;
        logic [MAX_NODES-1:0] frontier;
        logic [MAX_NODES-1:0] reach;
        logic [NODE_W-1:0]    comp_of [MAX_NODES];
        int                   n;
        int                   comps;
        label_t               lbl;
        if (it.kind == KIND_EDGE)
        begin
            bond_rows[it.node_a][it.node_b] = 1'b1;
            bond_rows[it.node_b][it.node_a] = 1'b1;
        end
        else
        begin
            n = (it.node_count > MAX_NODES) ? MAX_NODES : int'(it.node_count);
            in_range = (n >= MAX_NODES) ? '1 : ((64'd1 << n) - 64'd1);
            seen = '0;
            comps = 0;
            for (int s = 0; s < n; s++)
            begin
                if (!seen[s])
                begin
                    frontier = '0;
                    frontier[s] = 1'b1;
                    seen[s] = 1'b1;
                    comp_of[s] = NODE_W'(comps);
                    while (frontier != '0)
                    begin
                        reach = '0;
                        for (int i = 0; i < n; i++)
                        begin
                            if (frontier[i])
                                reach |= bond_rows[i];
                        end
                        reach &= in_range & ~seen;
                        for (int i = 0; i < n; i++)
                        begin
                            if (reach[i])
                                comp_of[i] = NODE_W'(comps);
                        end
                        seen |= reach;
                        frontier = reach;
                    end
                    comps++;
                end
            end
            for (int i = 0; i < n; i++)
            begin
                lbl.node_index = NODE_W'(i);
                lbl.last = (i == n - 1);
                case (it.rule)
                    RULE_ISOLATED:
                    begin
                        lbl.component_id = NODE_W'(i);
                        lbl.component_count = CNT_W'(n);
                    end
                    RULE_SINGLE:
                    begin
                        lbl.component_id = '0;
                        lbl.component_count = CNT_W'(1);
                    end
                    default:
                    begin
                        lbl.component_id = comp_of[i];
                        lbl.component_count = CNT_W'(comps);
                    end
                endcase
                expected_labels.insert(expected_labels.size(), lbl);
            end
            foreach (bond_rows[i])
                bond_rows[i] = '0;
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_label();
        label_t want;
        if (expected_labels.size() == 0)
        begin
            $display("%0t: label item for node %0d with none expected",
                     $time, labels.node_index);
            errors++;
        end
        else
        begin
            want = expected_labels.pop_front();
            compare_field("node_index", want.node_index, labels.node_index);
            compare_field("component_id", want.component_id, labels.component_id);
            compare_field("component_count", want.component_count,
                          labels.component_count);
            compare_field("last", want.last, labels.last);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        bond_item_t seen_bond;
        if (labels.valid && labels.ready)
            check_label();
        if (bonds.valid && bonds.ready)
        begin
            seen_bond.kind = bonds.kind;
            seen_bond.node_a = bonds.node_a;
            seen_bond.node_b = bonds.node_b;
            seen_bond.node_count = bonds.node_count;
            seen_bond.rule = label_rule;
            record_bond(seen_bond);
        end
    end

    task automatic offer_bond(input bond_item_t it);
        burst = (offered >= BURST_FIRST) && (offered < BURST_LAST);
        while (!burst && $urandom_range(99) < 37)
        begin
            bonds.valid <= 1'b0;
            @(negedge clk);
        end
        bonds.valid      <= 1'b1;
        bonds.kind       <= it.kind;
        bonds.node_a     <= it.node_a;
        bonds.node_b     <= it.node_b;
        bonds.node_count <= it.node_count;
        label_rule       <= it.rule;
        do
            @(posedge clk);
        while (!bonds.ready);
        offered++;
        @(negedge clk);
    endtask

    initial
    begin : receiver
        int held;
        held = 0;
        labels.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && held < HOLD_CYCLES)
            begin
                labels.ready <= 1'b0;
                held++;
            end
            else
            begin
                labels.ready <= burst || ($urandom_range(99) >= 37);
            end
        end
    end

    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((bonds.valid && bonds.ready) || (labels.valid && labels.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        bond_item_t it;
        int         n;
        int         span;
        int         pick;
        int         bond_total;
        rst_n = 1'b0;
        burst = 1'b0;
        hold_request = 1'b0;
        offered = 0;
        errors = 0;
        label_rule = RULE_PREDICT;
        bonds.valid = 1'b0;
        bonds.kind = KIND_EDGE;
        bonds.node_a = '0;
        bonds.node_b = '0;
        bonds.node_count = '0;
        foreach (bond_rows[i])
            bond_rows[i] = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_bonds[i])
            offer_bond(directed_bonds[i]);

        hold_request = 1'b1;
        while (offered < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                n = 0;
            else if (pick < 15)
                n = $urandom_range(127, 65);
            else if (pick < 25)
                n = $urandom_range(64, 17);
            else
                n = $urandom_range(16, 1);
            span = (n == 0 || n > MAX_NODES) ? MAX_NODES : n;
            bond_total = (n > 16) ? $urandom_range(24) : $urandom_range(8);
            it.kind = KIND_EDGE;
            it.rule = RULE_PREDICT;
            repeat (bond_total)
            begin
                if ($urandom_range(9) == 0)
                begin
                    it.node_a = NODE_W'($urandom_range(63));
                    it.node_b = NODE_W'($urandom_range(63));
                end
                else
                begin
                    it.node_a = NODE_W'($urandom_range(span - 1));
                    it.node_b = NODE_W'($urandom_range(span - 1));
                end
                it.node_count = CNT_W'($urandom_range(127));
                offer_bond(it);
            end
            it.kind = KIND_END;
            it.node_a = NODE_W'($urandom_range(63));
            it.node_b = NODE_W'($urandom_range(63));
            it.node_count = CNT_W'(n);
            offer_bond(it);
        end
        bonds.valid <= 1'b0;

        while (expected_labels.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
